// ===== rtl/bpbt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pulse and blink timer package
// Shared types, command codes, register indexes and timing constants.
// ----------------------------------------------------------------------------
package bpbt_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    typedef enum logic [1:0] {
        CMD_CHECK  = 2'd0,
        CMD_PULSE  = 2'd1,
        CMD_BLINK  = 2'd2,
        CMD_TOGGLE = 2'd3
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_PERIOD  = 2'd0,
        REG_WARNING_PERIOD = 2'd1
    } t_reg_idx;

    localparam logic [15:0] NORMAL_PERIOD_RST  = 16'd500;
    localparam logic [15:0] WARNING_PERIOD_RST = 16'd250;
    localparam logic [31:0] DISABLE_PULSE_MS   = 32'd300;
    localparam logic [31:0] BLINK_PULSE_MS     = 32'd100;
    localparam logic [15:0] ENABLE_BLINKS      = 16'd2;

    typedef struct packed {
        t_cmd        command;
        logic [31:0] now;
        logic [15:0] duration;
        logic [15:0] blink_count;
        logic        warning;
    } t_in_item;

    typedef struct packed {
        logic buzzer_drive;
        logic enabled_flag;
    } t_out_item;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] value;
    } t_cfg_item;

endpackage

// ===== rtl/bpbt_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pulse and blink timer channels
// Valid/ready channels for command items, result items and register writes.
// ----------------------------------------------------------------------------
interface bpbt_in_if;
    import bpbt_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpbt_out_if;
    import bpbt_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bpbt_cfg_if;
    import bpbt_pkg::*;
    logic      valid;
    logic      ready;
    t_cfg_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/buzzer_pulse_and_blink_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pulse and blink timer core
// Each command item carries the millisecond time; one result item per command
// gives the buzzer drive and enable flag after that command. An item enters an
// input register, is evaluated combinationally against the timer state and
// lands in a result register, so one item is taken per clock while the output
// keeps accepting results. A result waiting on the output does not stop a new
// item from being registered; the input stalls only when both stages are full.
// ----------------------------------------------------------------------------
module buzzer_pulse_and_blink_timer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bpbt_in_if.sink    i_in,
    bpbt_cfg_if.sink   i_cfg,
    bpbt_out_if.source o_out
);
    import bpbt_pkg::*;

    logic        r_in_valid;
    t_in_item    r_in;
    logic        r_out_valid;
    t_out_item   r_out;

    logic [15:0] r_normal_period;
    logic [15:0] r_warning_period;

    logic        r_enabled,    n_enabled;
    logic        r_sounding,   n_sounding;
    logic [31:0] r_off_time,   n_off_time;
    logic [31:0] r_next_blink, n_next_blink;
    logic [15:0] r_blinks,     n_blinks;
    logic [15:0] r_period,     n_period;

    logic        advance;
    logic        in_xfer;

    function automatic logic time_past(input logic [31:0] now, input logic [31:0] t);
        logic [31:0] d;
        d = now - t;
        return (d != 32'd0) && !d[31];
    endfunction

    assign advance     = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || advance;
    assign in_xfer     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_comb begin
        n_enabled    = r_enabled;
        n_sounding   = r_sounding;
        n_off_time   = r_off_time;
        n_next_blink = r_next_blink;
        n_blinks     = r_blinks;
        n_period     = r_period;
        unique case (r_in.command)
            CMD_CHECK: begin
                if (r_sounding && time_past(r_in.now, r_off_time)) begin
                    n_sounding = 1'b0;
                end
                if ((r_blinks != 16'd0) && time_past(r_in.now, r_next_blink)) begin
                    if (r_enabled) begin
                        n_off_time = r_in.now + BLINK_PULSE_MS;
                        n_sounding = 1'b1;
                    end
                    n_blinks     = r_blinks - 16'd1;
                    n_next_blink = r_in.now + {16'd0, r_period};
                end
            end
            CMD_PULSE: begin
                if (r_enabled) begin
                    n_off_time = r_in.now + {16'd0, r_in.duration};
                    n_sounding = 1'b1;
                end
            end
            CMD_BLINK: begin
                if (r_enabled) begin
                    n_period     = r_in.warning ? r_warning_period : r_normal_period;
                    n_next_blink = r_in.now;
                    n_blinks     = r_in.blink_count;
                end
            end
            CMD_TOGGLE: begin
                if (!r_enabled) begin
                    n_enabled    = 1'b1;
                    n_period     = r_normal_period;
                    n_next_blink = r_in.now;
                    n_blinks     = ENABLE_BLINKS;
                end else begin
                    n_off_time = r_in.now + DISABLE_PULSE_MS;
                    n_sounding = 1'b1;
                    n_enabled  = 1'b0;
                end
            end
            default: begin
                n_enabled = r_enabled;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_normal_period  <= NORMAL_PERIOD_RST;
            r_warning_period <= WARNING_PERIOD_RST;
            r_enabled        <= 1'b1;
            r_sounding       <= 1'b0;
            r_off_time       <= 32'd0;
            r_next_blink     <= 32'd0;
            r_blinks         <= 16'd0;
            r_period         <= 16'd0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid  <= 1'b1;
                r_enabled    <= n_enabled;
                r_sounding   <= n_sounding;
                r_off_time   <= n_off_time;
                r_next_blink <= n_next_blink;
                r_blinks     <= n_blinks;
                r_period     <= n_period;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.data.index)
                    REG_NORMAL_PERIOD:  r_normal_period  <= i_cfg.data.value;
                    REG_WARNING_PERIOD: r_warning_period <= i_cfg.data.value;
                    default: begin
                        r_normal_period <= r_normal_period;
                    end
                endcase
            end
        end
    end

    // hold payload registers; load on transfer
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in.data;
        end
        if (advance) begin
            r_out.buzzer_drive <= n_sounding;
            r_out.enabled_flag <= n_enabled;
        end
    end

endmodule

// ===== dv/tb_buzzer_pulse_and_blink_timer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buzzer pulse and blink timer core testbench
// Drives timed commands through the command channel, predicts the buzzer drive
// and enable flag after every command and compares each result transfer with
// the oldest prediction. Blink periods are reloaded between phases, including
// the extremes. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_buzzer_pulse_and_blink_timer_core;
    import bpbt_pkg::*;

    localparam int unsigned RAND_CMDS_PER_PHASE = 220;
    localparam int unsigned NUM_PHASES          = 5;

    logic i_clk;
    logic i_rst_n;

    bpbt_in_if  cmd_ch ();
    bpbt_cfg_if cfg_ch ();
    bpbt_out_if drive_ch ();

    buzzer_pulse_and_blink_timer_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .i_cfg   (cfg_ch),
        .o_out   (drive_ch)
    );

    // predicted timer state
    logic        buzz_enabled;
    logic        buzz_on;
    logic [31:0] off_deadline_ms;
    logic [31:0] next_blink_ms;
    logic [15:0] blinks_left;
    logic [15:0] blink_period;
    logic [15:0] normal_period;
    logic [15:0] warning_period;

    t_in_item    cmd_pending[$];
    t_out_item   drive_expected[$];
    int unsigned cmds_queued;
    int unsigned cmds_taken;
    int unsigned mismatch_count;
    logic [31:0] clock_ms;

    logic        cmd_taken;
    int unsigned burst_left;
    int unsigned gap_left;
    int unsigned pattern_age;
    logic [15:0] ready_pattern;

    function automatic logic time_past(logic [31:0] now, logic [31:0] mark);
        logic [31:0] diff;
        diff = now - mark;
        return (diff != 32'd0) && !diff[31];
    endfunction

    function automatic void start_pulse(logic [31:0] now, logic [31:0] len_ms);
        if (buzz_enabled) begin
            off_deadline_ms = now + len_ms;
            buzz_on         = 1'b1;
        end
    endfunction

    function automatic void start_blinks(logic [31:0] now, logic [15:0] count, logic warn);
        if (buzz_enabled) begin
            blink_period  = warn ? warning_period : normal_period;
            next_blink_ms = now;
            blinks_left   = count;
        end
    endfunction

    function automatic t_out_item apply_command(t_in_item c);
        t_out_item r;
        case (c.command)
            CMD_CHECK: begin
                if (buzz_on && time_past(c.now, off_deadline_ms)) begin
                    buzz_on = 1'b0;
                end
                if (blinks_left != 16'd0 && time_past(c.now, next_blink_ms)) begin
                    start_pulse(c.now, BLINK_PULSE_MS);
                    blinks_left   = blinks_left - 16'd1;
                    next_blink_ms = c.now + {16'd0, blink_period};
                end
            end
            CMD_PULSE: start_pulse(c.now, {16'd0, c.duration});
            CMD_BLINK: start_blinks(c.now, c.blink_count, c.warning);
            default: begin
                if (!buzz_enabled) begin
                    buzz_enabled = 1'b1;
                    start_blinks(c.now, ENABLE_BLINKS, 1'b0);
                end else begin
                    start_pulse(c.now, DISABLE_PULSE_MS);
                    buzz_enabled = 1'b0;
                end
            end
        endcase
        r.buzzer_drive = buzz_on;
        r.enabled_flag = buzz_enabled;
        return r;
    endfunction

    task automatic queue_command(t_cmd cmd, logic [31:0] now, logic [15:0] dur,
                                 logic [15:0] cnt, logic warn);
        t_in_item it;
        it.command     = cmd;
        it.now         = now;
        it.duration    = dur;
        it.blink_count = cnt;
        it.warning     = warn;
        cmd_pending.push_back(it);
        cmds_queued++;
    endtask

    task automatic queue_random_command();
        int unsigned pick;
        t_cmd        cmd;
        logic [15:0] dur;
        logic [15:0] cnt;
        pick = $urandom_range(0, 99);
        if (pick < 2) begin
            clock_ms = $urandom();
        end else if (pick < 4) begin
            clock_ms = clock_ms + 32'h7FFF_FFFF + $urandom_range(0, 2);
        end else begin
            clock_ms = clock_ms + $urandom_range(0, 120);
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            cmd = CMD_CHECK;
        end else if (pick < 72) begin
            cmd = CMD_PULSE;
        end else if (pick < 88) begin
            cmd = CMD_BLINK;
        end else begin
            cmd = CMD_TOGGLE;
        end
        dur = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 400));
        cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 4));
        queue_command(cmd, clock_ms, dur, cnt, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_idle();
        while (cmds_taken != cmds_queued || drive_expected.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (3) @(negedge i_clk);
    endtask

    task automatic load_periods(logic [15:0] normal_ms, logic [15:0] warning_ms);
        cfg_ch.data  <= '{index: REG_NORMAL_PERIOD, value: normal_ms};
        cfg_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        normal_period = normal_ms;
        @(negedge i_clk);
        cfg_ch.data <= '{index: REG_WARNING_PERIOD, value: warning_ms};
        do @(posedge i_clk); while (!cfg_ch.ready);
        warning_period = warning_ms;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // check result transfers, then predict for the command transfer of this edge
    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
        end else begin
            if (drive_ch.valid && drive_ch.ready) begin
                if (drive_expected.size() == 0) begin
                    $error("unexpected result: buzzer_drive %0b enabled_flag %0b",
                           drive_ch.data.buzzer_drive, drive_ch.data.enabled_flag);
                    mismatch_count++;
                end else begin
                    want = drive_expected.pop_front();
                    if (drive_ch.data.buzzer_drive !== want.buzzer_drive) begin
                        $error("buzzer_drive: expected %0b, got %0b",
                               want.buzzer_drive, drive_ch.data.buzzer_drive);
                        mismatch_count++;
                    end
                    if (drive_ch.data.enabled_flag !== want.enabled_flag) begin
                        $error("enabled_flag: expected %0b, got %0b",
                               want.enabled_flag, drive_ch.data.enabled_flag);
                        mismatch_count++;
                    end
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                drive_expected.push_back(apply_command(cmd_ch.data));
                cmds_taken++;
            end
            cmd_taken <= cmd_ch.valid && cmd_ch.ready;
        end
    end

    // send commands in bursts with random gaps
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (!cmd_ch.valid || cmd_taken) begin
            if (gap_left != 0) begin
                cmd_ch.valid <= 1'b0;
                gap_left     <= gap_left - 1;
            end else if (cmd_pending.size() != 0) begin
                cmd_ch.data  <= cmd_pending.pop_front();
                cmd_ch.valid <= 1'b1;
                if (burst_left > 1) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                cmd_ch.valid <= 1'b0;
            end
        end
    end

    // stall results on a rotating pattern, reshuffled now and then
    always @(negedge i_clk) begin
        if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
                0:       ready_pattern = 16'hFFFF;
                1:       ready_pattern = 16'h0101;
                default: ready_pattern = 16'($urandom()) | 16'h0001;
            endcase
            pattern_age = $urandom_range(16, 96);
        end
        pattern_age    = pattern_age - 1;
        drive_ch.ready <= ready_pattern[0];
        ready_pattern  = {ready_pattern[0], ready_pattern[15:1]};
    end

    initial begin
        i_rst_n        = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.data    = '0;
        cfg_ch.valid   = 1'b0;
        cfg_ch.data    = '0;
        drive_ch.ready = 1'b0;
        cmd_taken      = 1'b0;
        burst_left     = 1;
        gap_left       = 0;
        pattern_age    = 0;
        ready_pattern  = 16'hFFFF;
        mismatch_count = 0;
        cmds_queued    = 0;
        cmds_taken     = 0;

        buzz_enabled    = 1'b1;
        buzz_on         = 1'b0;
        off_deadline_ms = '0;
        next_blink_ms   = '0;
        blinks_left     = '0;
        blink_period    = '0;
        normal_period   = NORMAL_PERIOD_RST;
        warning_period  = WARNING_PERIOD_RST;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        queue_command(CMD_CHECK,  32'd0,          16'd0,     16'd0,     1'b0);
        // zero-length pulse: on until strictly past its deadline
        queue_command(CMD_PULSE,  32'd0,          16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd0,          16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd1,          16'd0,     16'd0,     1'b0);
        // deadline wraps past zero
        queue_command(CMD_PULSE,  32'hFFFF_FFF0,  16'hFFFF,  16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'h0000_0010,  16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'h0000_FFF0,  16'd0,     16'd0,     1'b0);
        // zero blink count
        queue_command(CMD_BLINK,  32'd1000,       16'd0,     16'd0,     1'b1);
        queue_command(CMD_CHECK,  32'd2000,       16'd0,     16'd0,     1'b0);
        // warning blinks; second blink lands after the first switches off
        queue_command(CMD_BLINK,  32'd2000,       16'd0,     16'd2,     1'b1);
        queue_command(CMD_CHECK,  32'd2000,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd2001,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd2252,       16'd0,     16'd0,     1'b0);
        // disable, then requests are ignored and the pulse still ends
        queue_command(CMD_TOGGLE, 32'd2300,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_PULSE,  32'd2400,       16'd5,     16'd0,     1'b0);
        queue_command(CMD_BLINK,  32'd2400,       16'd0,     16'd3,     1'b1);
        queue_command(CMD_CHECK,  32'd2700,       16'd0,     16'd0,     1'b0);
        // enable then disable at once: blinks run down silently
        queue_command(CMD_TOGGLE, 32'd3000,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_TOGGLE, 32'd3000,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd3001,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'd3600,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_TOGGLE, 32'd3700,       16'd0,     16'd0,     1'b0);
        queue_command(CMD_BLINK,  32'hFFFF_FFFF,  16'hFFFF,  16'hFFFF,  1'b0);
        queue_command(CMD_CHECK,  32'd0,          16'd0,     16'd0,     1'b0);
        queue_command(CMD_CHECK,  32'h8000_0000,  16'd0,     16'd0,     1'b1);
        wait_idle();

        clock_ms = 32'h8000_0100;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0:       load_periods(16'd0,     16'hFFFF);
                1:       load_periods(16'hFFFF,  16'd0);
                2:       load_periods(16'd1,     16'd1);
                3:       load_periods(16'($urandom()), 16'($urandom()));
                default: load_periods(16'd180,   16'd90);
            endcase
            repeat (RAND_CMDS_PER_PHASE) queue_random_command();
            wait_idle();
        end

        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
